// File: rtl/cplm_pkg.sv
// Shared constants and types of the cascaded position and speed motor loop.
package cplm_pkg;

    localparam int DUTY_MAX     = 255;
    localparam int ACC_FRACTION = 32;
    localparam int ACC_BOUND    = DUTY_MAX * ACC_FRACTION;
    localparam int ACC_W        = $clog2(ACC_BOUND + 1) + 1;
    localparam int DUTY_W       = 8;

    localparam int POS_W  = 16;
    localparam int LIM_W  = 15;
    localparam int GAIN_W = 8;
    localparam int DB_W   = 10;
    localparam int SCL_W  = 15;

    localparam int MC_W   = 16;
    localparam int MP_W   = 15;
    localparam int PROD_W = 32;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 32;

    localparam logic [SCL_W-1:0] SCALE_RESET = SCL_W'(1000);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET_POSITION   = 3'd0,
        REG_SPEED_LIMIT       = 3'd1,
        REG_POSITION_GAIN     = 3'd2,
        REG_SPEED_GAIN        = 3'd3,
        REG_POSITION_DEADBAND = 3'd4,
        REG_MIN_DUTY          = 3'd5,
        REG_TICK_RATE_SCALE   = 3'd6,
        REG_ENCODER_INVERT    = 3'd7
    } cfg_idx_t;

endpackage

// File: rtl/cascaded_position_speed_motor_loop.sv
// Cascaded position/speed motor loop (proportional position, accumulating speed stage), one control tick per transfer.
// Steps: take the input, then three serial products on one shared multiplier (position
// gain, tick scale, speed gain), then the result is registered for output.
// Throughput: one tick at a time; the shared bit-serial multiplier and output back-pressure set the rate.
// Reset: registers to defaults (tick scale 1000), accumulator and previous
// position cleared, direction toward the closed end, no result pending.
module cascaded_position_speed_motor_loop
    import cplm_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // encoder_count[15:0], open_stop_level[16], closed_stop_level[17], zero fill
    input  logic [IN_DATA_W-1:0]    s_axis_tdata,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // pwm_duty[7:0], drive_direction[8], speed_command[24:9], zero fill
    output logic [OUT_DATA_W-1:0]   m_axis_tdata
);

    typedef enum logic [2:0] {
        S_IDLE, S_POS_GO, S_POS_RUN, S_SPD_GO, S_SPD_RUN, S_ACC_GO, S_ACC_RUN, S_FIN
    } state_t;

    state_t state_reg;

    logic signed [POS_W-1:0] target_reg;
    logic        [LIM_W-1:0] limit_reg;
    logic        [GAIN_W-1:0] pgain_reg;
    logic        [GAIN_W-1:0] sgain_reg;
    logic        [DB_W-1:0]  deadband_reg;
    logic        [DUTY_W-1:0] min_duty_reg;
    logic        [SCL_W-1:0] scale_reg;
    logic                    invert_reg;

    logic signed [POS_W-1:0] prev_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic                    dir_reg;

    logic signed [POS_W-1:0] pos_reg;
    logic signed [POS_W-1:0] err_reg;
    logic signed [POS_W-1:0] diff_reg;
    logic signed [POS_W-1:0] cmd_reg;
    logic signed [POS_W-1:0] serr_reg;
    logic signed [ACC_W-1:0] sum_reg;
    logic                    open_reg;
    logic                    closed_reg;

    logic                    out_valid_reg;
    logic [DUTY_W-1:0]       duty_out_reg;
    logic                    dir_out_reg;
    logic signed [POS_W-1:0] cmd_out_reg;

    logic signed [POS_W-1:0] enc;
    logic signed [POS_W-1:0] pos_next;
    logic signed [POS_W-1:0] err_raw;
    logic        [POS_W:0]   err_mag;
    logic signed [POS_W-1:0] err_next;

    logic                     mul_start;
    logic signed [MC_W-1:0]   mul_mcand;
    logic        [MP_W-1:0]   mul_mplier;
    logic                     mul_done;
    logic signed [PROD_W-1:0] mul_prod;

    logic signed [PROD_W-1:0] lim_pos;
    logic signed [PROD_W-1:0] lim_neg;
    logic signed [POS_W-1:0]  cmd_next;
    logic signed [POS_W-1:0]  serr_next;
    logic signed [PROD_W-1:0] inc;
    logic signed [PROD_W-1:0] sum_full;
    logic signed [ACC_W-1:0]  sum_next;

    logic        [ACC_W-1:0]  sum_mag;
    logic        [DUTY_W-1:0] duty_raw;
    logic                     gate_off;
    logic                     dir_next;
    logic                     out_free;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, cmd_out_reg, dir_out_reg, duty_out_reg};
    assign out_free      = !out_valid_reg || m_axis_tready;

    assign enc      = s_axis_tdata[POS_W-1:0];
    assign pos_next = invert_reg ? -enc : enc;
    assign err_raw  = target_reg - pos_next;
    assign err_mag  = err_raw[POS_W-1] ? (POS_W+1)'(-$signed({err_raw[POS_W-1], err_raw}))
                                       : {1'b0, err_raw};
    assign err_next = (err_mag < (POS_W+1)'(deadband_reg)) ? '0 : err_raw;

    always_comb
    begin
        mul_start  = 1'b0;
        mul_mcand  = err_reg;
        mul_mplier = MP_W'(pgain_reg);
        unique case (state_reg)
            S_POS_GO:
            begin
                mul_start = 1'b1;
            end
            S_SPD_GO, S_SPD_RUN:
            begin
                mul_start  = (state_reg == S_SPD_GO);
                mul_mcand  = diff_reg;
                mul_mplier = scale_reg;
            end
            S_ACC_GO, S_ACC_RUN:
            begin
                mul_start  = (state_reg == S_ACC_GO);
                mul_mcand  = serr_reg;
                mul_mplier = MP_W'(sgain_reg);
            end
            default:
            begin
                mul_start = 1'b0;
            end
        endcase
    end

    cplm_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .mcand   (mul_mcand),
        .mplier  (mul_mplier),
        .done    (mul_done),
        .product (mul_prod)
    );

    assign lim_pos  = $signed(PROD_W'(limit_reg));
    assign lim_neg  = -lim_pos;
    assign cmd_next = (mul_prod > lim_pos) ? POS_W'(lim_pos) :
                      (mul_prod < lim_neg) ? POS_W'(lim_neg) : POS_W'(mul_prod);
    assign serr_next = cmd_reg - POS_W'(mul_prod);

    assign inc      = mul_prod[PROD_W-1] ? ((mul_prod + PROD_W'(3)) >>> 2) : (mul_prod >>> 2);
    assign sum_full = PROD_W'(acc_reg) + inc;
    assign sum_next = (sum_full > PROD_W'(ACC_BOUND))    ? ACC_W'(ACC_BOUND) :
                      (sum_full < -(PROD_W'(ACC_BOUND))) ? ACC_W'(-ACC_BOUND) :
                      ACC_W'(sum_full);

    assign sum_mag  = sum_reg[ACC_W-1] ? ACC_W'(-sum_reg) : ACC_W'(sum_reg);
    assign duty_raw = DUTY_W'(sum_mag / ACC_FRACTION);
    assign gate_off = (cmd_reg[POS_W-1] && !open_reg)
                   || (!cmd_reg[POS_W-1] && (cmd_reg != '0) && !closed_reg)
                   || (duty_raw < min_duty_reg)
                   || (cmd_reg == '0);
    assign dir_next = sum_reg[ACC_W-1] ? 1'b0 : ((sum_reg != '0) ? 1'b1 : dir_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg   <= '0;
            limit_reg    <= '0;
            pgain_reg    <= '0;
            sgain_reg    <= '0;
            deadband_reg <= '0;
            min_duty_reg <= '0;
            scale_reg    <= SCALE_RESET;
            invert_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_TARGET_POSITION:   target_reg   <= cfg_data;
                REG_SPEED_LIMIT:       limit_reg    <= cfg_data[LIM_W-1:0];
                REG_POSITION_GAIN:     pgain_reg    <= cfg_data[GAIN_W-1:0];
                REG_SPEED_GAIN:        sgain_reg    <= cfg_data[GAIN_W-1:0];
                REG_POSITION_DEADBAND: deadband_reg <= cfg_data[DB_W-1:0];
                REG_MIN_DUTY:          min_duty_reg <= cfg_data[DUTY_W-1:0];
                REG_TICK_RATE_SCALE:   scale_reg    <= cfg_data[SCL_W-1:0];
                REG_ENCODER_INVERT:    invert_reg   <= cfg_data[0];
                default:               invert_reg   <= invert_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            prev_reg      <= '0;
            acc_reg       <= '0;
            dir_reg       <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && m_axis_tready && (state_reg != S_FIN))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        state_reg <= S_POS_GO;
                    end
                end
                S_POS_GO:  state_reg <= S_POS_RUN;
                S_POS_RUN:
                begin
                    if (mul_done)
                    begin
                        state_reg <= S_SPD_GO;
                    end
                end
                S_SPD_GO:  state_reg <= S_SPD_RUN;
                S_SPD_RUN:
                begin
                    if (mul_done)
                    begin
                        state_reg <= S_ACC_GO;
                    end
                end
                S_ACC_GO:  state_reg <= S_ACC_RUN;
                S_ACC_RUN:
                begin
                    if (mul_done)
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    if (out_free)
                    begin
                        state_reg     <= S_IDLE;
                        out_valid_reg <= 1'b1;
                        prev_reg      <= pos_reg;
                        acc_reg       <= sum_reg;
                        dir_reg       <= dir_next;
                    end
                end
                default:   state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            pos_reg    <= pos_next;
            err_reg    <= err_next;
            diff_reg   <= pos_next - prev_reg;
            open_reg   <= s_axis_tdata[POS_W];
            closed_reg <= s_axis_tdata[POS_W+1];
        end
        if (state_reg == S_POS_RUN && mul_done)
        begin
            cmd_reg <= cmd_next;
        end
        if (state_reg == S_SPD_RUN && mul_done)
        begin
            serr_reg <= serr_next;
        end
        if (state_reg == S_ACC_RUN && mul_done)
        begin
            sum_reg <= sum_next;
        end
        if (state_reg == S_FIN && out_free)
        begin
            duty_out_reg <= gate_off ? '0 : duty_raw;
            dir_out_reg  <= dir_next;
            cmd_out_reg  <= cmd_reg;
        end
    end

endmodule

// File: rtl/cplm_mul.sv
// Bit-serial shift-add multiplier: signed multiplicand, unsigned multiplier.
module cplm_mul
    import cplm_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [MC_W-1:0]   mcand,
    input  logic        [MP_W-1:0]   mplier,
    output logic                     done,
    output logic signed [PROD_W-1:0] product
);

    logic                     busy_reg;
    logic signed [PROD_W-1:0] mc_reg;
    logic        [MP_W-1:0]   mp_reg;
    logic signed [PROD_W-1:0] acc_reg;
    logic signed [PROD_W-1:0] acc_next;

    assign acc_next = mp_reg[0] ? acc_reg + mc_reg : acc_reg;
    assign done     = busy_reg && (mp_reg == '0);
    assign product  = acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
        end
        else if (done)
        begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mc_reg  <= PROD_W'(mcand);
            mp_reg  <= mplier;
            acc_reg <= '0;
        end
        else if (busy_reg && (mp_reg != '0))
        begin
            acc_reg <= acc_next;
            mc_reg  <= mc_reg <<< 1;
            mp_reg  <= mp_reg >> 1;
        end
    end

endmodule

// File: rtl/cplm_checker.sv
// Port-level assertions for the motor loop, bound to the top level.
module cplm_checker
    import cplm_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after a transfer");

    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared without a tick in progress");

    a_zero_cmd_no_duty: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[24:9] == 16'd0) |-> (m_axis_tdata[7:0] == 8'd0))
        else $error("nonzero duty with zero speed command");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind cascaded_position_speed_motor_loop cplm_checker u_cplm_checker (.*);

// File: tb/tb_cascaded_position_speed_motor_loop.sv
// Self-checking testbench for the cascaded position and speed motor loop.
`timescale 1ns / 1ps

module tb_cascaded_position_speed_motor_loop;
    import cplm_pkg::*;

    localparam int HALF_PERIOD     = 6;
    localparam int RESET_CYCLES    = 9;
    localparam int SETTLE_CYCLES   = 48;
    localparam int HOLD_CYCLES     = 300;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int RANDOM_PHASES   = 18;
    localparam int ITEMS_PER_PHASE = 80;

    typedef logic [CFG_DATA_W-1:0] reg_bank_t [8];

    typedef struct packed {
        logic [15:0] speed_command;
        logic        drive_direction;
        logic [7:0]  pwm_duty;
    } tick_out_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    reg_bank_t   loop_regs;
    logic [15:0] last_position;
    int          drive_acc;
    logic        heading;
    logic [15:0] shaft;

    tick_out_t pending_outputs [$];
    int        errors;
    int        results_checked;
    int        settings_applied;
    int        quiet_cycles;
    bit        idle_on;
    bit        stall_on;
    bit        hold_request;

    cascaded_position_speed_motor_loop dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #HALF_PERIOD clk = ~clk;

    function automatic int wrap16(int x);
        return int'($signed(x[15:0]));
    endfunction

    function automatic tick_out_t control_tick(logic [15:0] enc, logic open_lv,
                                               logic closed_lv);
        tick_out_t o;
        int        pos, err, lim, cmd, diff, meas, serr, inc, sum, duty;
        pos = int'($signed(enc));
        if (loop_regs[REG_ENCODER_INVERT][0])
            pos = wrap16(-pos);
        err = wrap16(int'($signed(loop_regs[REG_TARGET_POSITION])) - pos);
        if ((err < 0 ? -err : err) < int'(loop_regs[REG_POSITION_DEADBAND][DB_W-1:0]))
            err = 0;
        lim = int'(loop_regs[REG_SPEED_LIMIT][LIM_W-1:0]);
        cmd = err * int'(loop_regs[REG_POSITION_GAIN][GAIN_W-1:0]);
        if (cmd > lim)
            cmd = lim;
        if (cmd < -lim)
            cmd = -lim;
        diff = wrap16(pos - int'($signed(last_position)));
        meas = wrap16(int'(loop_regs[REG_TICK_RATE_SCALE][SCL_W-1:0]) * diff);
        serr = wrap16(cmd - meas);
        inc  = serr * int'(loop_regs[REG_SPEED_GAIN][GAIN_W-1:0]) / 4;
        sum  = drive_acc + inc;
        if (sum > ACC_BOUND)
            sum = ACC_BOUND;
        if (sum < -ACC_BOUND)
            sum = -ACC_BOUND;
        drive_acc = sum;
        if (sum < 0)
            heading = 1'b0;
        else if (sum > 0)
            heading = 1'b1;
        duty = sum / ACC_FRACTION;
        if (duty < 0)
            duty = -duty;
        if ((cmd < 0 && !open_lv) || (cmd > 0 && !closed_lv) || cmd == 0 ||
            duty < int'(loop_regs[REG_MIN_DUTY][DUTY_W-1:0]))
            duty = 0;
        last_position = pos[15:0];
        o.pwm_duty        = duty[7:0];
        o.drive_direction = heading;
        o.speed_command   = cmd[15:0];
        return o;
    endfunction

    function automatic reg_bank_t random_bank(int mode);
        reg_bank_t b;
        case (mode)
            0: foreach (b[i]) b[i] = 16'($urandom);
            1:
            begin
                foreach (b[i]) b[i] = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
                b[REG_TARGET_POSITION] = ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
            end
            default:
            begin
                b[REG_TARGET_POSITION]   = 16'($urandom);
                b[REG_SPEED_LIMIT]       = 16'($urandom_range(0, 32767));
                b[REG_POSITION_GAIN]     = 16'($urandom_range(0, 16));
                b[REG_SPEED_GAIN]        = 16'($urandom_range(0, 64));
                b[REG_POSITION_DEADBAND] = 16'($urandom_range(0, 64));
                b[REG_MIN_DUTY]          = 16'($urandom_range(0, 40));
                b[REG_TICK_RATE_SCALE]   = 16'($urandom_range(1, 200));
                b[REG_ENCODER_INVERT]    = 16'($urandom_range(0, 1));
            end
        endcase
        return b;
    endfunction

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_outputs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apply_settings(reg_bank_t bank);
        cfg_idx_t idx;
        settle();
        idx = idx.first();
        repeat (idx.num())
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= bank[idx];
            @(posedge clk);
            idx = idx.next();
        end
        cfg_we <= 1'b0;
        loop_regs = bank;
        settings_applied++;
    endtask

    task automatic send_tick(logic [15:0] enc, logic open_lv, logic closed_lv);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, closed_lv, open_lv, enc};
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_outputs.push_back(control_tick(enc, open_lv, closed_lv));
    endtask

    // Track the target with a noisy shaft, with rare jumps and end-stop hits.
    task automatic run_trajectory(int count);
        logic [15:0] goal;
        int          delta, step;
        goal = loop_regs[REG_ENCODER_INVERT][0] ? 16'h0000 - loop_regs[REG_TARGET_POSITION]
                                                : loop_regs[REG_TARGET_POSITION];
        shaft = goal + 16'($urandom_range(0, 1600)) - 16'd800;
        repeat (count)
        begin
            case ($urandom_range(0, 15))
                0: shaft = 16'($urandom);
                1, 2, 3: shaft = shaft + 16'($urandom_range(0, 64)) - 16'd32;
                default:
                begin
                    step  = $urandom_range(0, 40);
                    delta = wrap16(int'(goal) - int'(shaft));
                    if (delta > step)
                        shaft = shaft + 16'(step);
                    else if (delta < -step)
                        shaft = shaft - 16'(step);
                    else
                        shaft = goal;
                end
            endcase
            send_tick(shaft, $urandom_range(0, 9) != 0, $urandom_range(0, 9) != 0);
        end
    endtask

    task automatic test_reset_defaults();
        send_tick(16'h8000, 1'b1, 1'b1);
        send_tick(16'h7FFF, 1'b0, 1'b0);
        send_tick(16'h0000, 1'b1, 1'b1);
    endtask

    task automatic test_directed_extremes();
        reg_bank_t b;
        b = '{16'd1000, 16'h7FFF, 16'd255, 16'd255, 16'd0, 16'd0, 16'd1000, 16'd0};
        apply_settings(b);
        send_tick(16'h0000, 1'b1, 1'b1);
        send_tick(16'h7FFF, 1'b1, 1'b1);
        send_tick(16'h8000, 1'b1, 1'b1);
        send_tick(16'd1000, 1'b1, 1'b1);
        send_tick(16'd500, 1'b1, 1'b0);
        send_tick(16'd1500, 1'b0, 1'b1);
        send_tick(16'h0000, 1'b0, 1'b0);
        b = '{16'h8000, 16'd0, 16'd1, 16'd1, 16'd1023, 16'd255, 16'd0, 16'd1};
        apply_settings(b);
        send_tick(16'h8000, 1'b1, 1'b1);
        send_tick(16'h8300, 1'b1, 1'b1);
        send_tick(16'h7FFF, 1'b1, 1'b1);
        b = '{16'd0, 16'd100, 16'd255, 16'd4, 16'd10, 16'd1, 16'h7FFF, 16'd1};
        apply_settings(b);
        send_tick(16'd9, 1'b1, 1'b1);
        send_tick(-16'sd10, 1'b1, 1'b1);
        send_tick(16'd10, 1'b1, 1'b1);
        send_tick(-16'sd9, 1'b1, 1'b1);
        send_tick(16'h7FFF, 1'b1, 1'b1);
        send_tick(16'h8000, 1'b1, 1'b1);
        b = '{default: 16'hFFFF};
        apply_settings(b);
        send_tick(16'd5, 1'b1, 1'b1);
        send_tick(-16'sd3, 1'b0, 1'b0);
    endtask

    task automatic test_output_hold_off();
        apply_settings(random_bank(2));
        hold_request = 1'b1;
        run_trajectory(20);
        settle();
    endtask

    task automatic test_random_phases();
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            idle_on  = (p % 3) != 2;
            stall_on = (p % 4) != 3;
            apply_settings(random_bank($urandom_range(0, 5)));
            run_trajectory(ITEMS_PER_PHASE);
        end
    endtask

    task automatic test_full_rate();
        idle_on  = 1'b0;
        stall_on = 1'b0;
        apply_settings(random_bank(2));
        run_trajectory(140);
    endtask

    // Ready side: random short stalls, one long hold-off on request.
    initial
    begin : receiver
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else if (stall_on && $urandom_range(0, 3) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        tick_out_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_checked++;
            if (pending_outputs.size() == 0)
            begin
                $error("result transfer with nothing pending: tdata %h", m_axis_tdata);
                errors++;
            end
            else
            begin
                want = pending_outputs.pop_front();
                if (m_axis_tdata[7:0] !== want.pwm_duty)
                begin
                    $error("pwm_duty: expected %0d, got %0d", want.pwm_duty, m_axis_tdata[7:0]);
                    errors++;
                end
                if (m_axis_tdata[8] !== want.drive_direction)
                begin
                    $error("drive_direction: expected %0d, got %0d",
                           want.drive_direction, m_axis_tdata[8]);
                    errors++;
                end
                if (m_axis_tdata[24:9] !== want.speed_command)
                begin
                    $error("speed_command: expected %0d, got %0d",
                           $signed(want.speed_command), $signed(m_axis_tdata[24:9]));
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no transfer for %0d cycles", quiet_cycles);
            $display("FAILURE");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        s_axis_tvalid    = 1'b0;
        s_axis_tdata     = '0;
        errors           = 0;
        results_checked  = 0;
        settings_applied = 0;
        quiet_cycles     = 0;
        idle_on          = 1'b1;
        stall_on         = 1'b1;
        hold_request     = 1'b0;
        loop_regs        = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1000, 16'd0};
        last_position    = '0;
        drive_acc        = 0;
        heading          = 1'b1;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_directed_extremes();
        test_output_hold_off();
        test_random_phases();
        test_full_rate();
        settle();

        $display("Checked %0d control ticks over %0d register settings,", results_checked,
                 settings_applied);
        $display("with directed extremes, random bursts and a long output hold-off.");
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: files.f
rtl/cplm_pkg.sv
rtl/cplm_mul.sv
rtl/cascaded_position_speed_motor_loop.sv
rtl/cplm_checker.sv
tb/tb_cascaded_position_speed_motor_loop.sv
